// File: rtl/bb3_pkg.sv
package bb3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CFG_W          = 11;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_done;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift;
    logic div_start;
    logic restart;
  } dp_cmd_t;

  typedef struct packed {
    logic take;
    logic emit;
    logic div_busy;
  } dp_stat_t;

  // Row and column masks of the neighbourhood give a count of 1, 2, 3, 4, 6 or 9.
  function automatic logic [3:0] nb_count(input logic [1:0] nr, input logic [1:0] nc);
    logic [3:0] p;
    p = 4'(nr) * 4'(nc);
    return p;
  endfunction

endpackage

// File: rtl/bb3_div.sv
module bb3_div (
  input  logic [11:0] sum,
  input  logic [3:0]  count,
  output logic [7:0]  quo
);

  // The mean is floor((2*sum + count) / (2*count)). Halving the numerator first leaves a
  // shift, or a division by three or nine, done by multiplying with a 16-bit reciprocal.
  localparam logic [15:0] RECIP_3 = 16'd21846;
  localparam logic [15:0] RECIP_9 = 16'd7282;

  logic [11:0] half;
  logic [23:0] by3_full, by3_half, by9_full;

  always_comb begin
    half     = sum + 12'(count[3:1]);
    by3_full = 24'(half) * 24'(RECIP_3);
    by3_half = 24'(half[11:1]) * 24'(RECIP_3);
    by9_full = 24'(half) * 24'(RECIP_9);
    case (count)
      4'd1:    quo = half[7:0];
      4'd2:    quo = half[8:1];
      4'd4:    quo = half[9:2];
      4'd3:    quo = 8'(by3_full >> 16);
      4'd6:    quo = 8'(by3_half >> 16);
      4'd9:    quo = 8'(by9_full >> 16);
      default: quo = '0;
    endcase
  end

endmodule

// File: rtl/bb3_datapath.sv
module bb3_datapath #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bb3_pkg::in_word_t     in_word,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
  input  bb3_pkg::dp_cmd_t      cmd,
  output bb3_pkg::dp_stat_t     stat,
  output bb3_pkg::out_word_t    out_word
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [CW-1:0] width_r;
  logic [RW-1:0] height_r;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [23:0]   win_r [9];
  logic [23:0]   top_mem [MAX_WIDTH];
  logic [23:0]   mid_mem [MAX_WIDTH];
  logic [23:0]   top_q, mid_q;
  logic [23:0]   pix_r;
  logic          primed_r, done_r;
  logic [3:0]    count_r;
  logic [11:0]   sum_r [3];
  logic          calc_r;
  logic [7:0]    res_r [3];

  logic        pixel_phase, drain;
  logic [23:0] pix;

  assign pixel_phase = in_row_r < height_r;
  assign drain       = in_word.action == bb3_pkg::ACT_DRAIN;
  assign pix = drain ? 24'd0 : {in_word.red_in, in_word.green_in, in_word.blue_in};

  function automatic logic [CW-1:0] clamp_w(input logic [bb3_pkg::CFG_W-1:0] v);
    if (v == '0) return CW'(1);
    if (32'(v) > MAX_WIDTH) return CW'(MAX_WIDTH);
    return CW'(v);
  endfunction

  function automatic logic [RW-1:0] clamp_h(input logic [bb3_pkg::CFG_W-1:0] v);
    if (v == '0) return RW'(1);
    if (32'(v) > MAX_HEIGHT) return RW'(MAX_HEIGHT);
    return RW'(v);
  endfunction

  // Line stores are read in the cycle the word is taken and written in the shift cycle.
  always_ff @(posedge clk) begin
    top_q <= top_mem[in_col_r[AW-1:0]];
    mid_q <= mid_mem[in_col_r[AW-1:0]];
    if (cmd.shift) begin
      top_mem[in_col_r[AW-1:0]] <= mid_q;
      mid_mem[in_col_r[AW-1:0]] <= pix_r;
    end
  end

  // Masks and sums from the window after the shift.
  logic        use_t, use_b, use_l, use_r;
  logic [1:0]  nr, nc;
  logic [11:0] s [3];
  logic        done_c;
  logic [23:0] w [9];

  always_comb begin
    for (int i = 0; i < 9; i++) w[i] = win_r[i];
    use_t = out_row_r != '0;
    use_b = (32'(out_row_r) + 1) < 32'(height_r);
    use_l = out_col_r != '0;
    use_r = (32'(out_col_r) + 1) < 32'(width_r);
    nr = 2'd1 + 2'(use_t) + 2'(use_b);
    nc = 2'd1 + 2'(use_l) + 2'(use_r);
    for (int k = 0; k < 3; k++) begin
      s[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r != 0 || use_t) && (r != 2 || use_b) && (c != 0 || use_l) &&
              (c != 2 || use_r))
            s[k] = s[k] + 12'(w[r*3+c][23-8*k -: 8]);
        end
      end
    end
    done_c = (32'(out_row_r) + 1 == 32'(height_r)) && (32'(out_col_r) + 1 == 32'(width_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= clamp_w(bb3_pkg::CFG_W'(1024));
      height_r  <= clamp_h(bb3_pkg::CFG_W'(1024));
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      primed_r  <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bb3_pkg::CFG_IDX_WIDTH) width_r <= clamp_w(cfg_data);
      else height_r <= clamp_h(cfg_data);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.restart) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_q;
      win_r[5] <= mid_q;
      win_r[8] <= pix_r;
      primed_r <= (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
      if (32'(in_col_r) + 1 >= 32'(width_r)) begin
        in_col_r <= '0;
        in_row_r <= in_row_r + RW'(1);
      end else begin
        in_col_r <= in_col_r + CW'(1);
      end
    end else if (cmd.div_start) begin
      if (32'(out_col_r) + 1 >= 32'(width_r)) begin
        out_col_r <= '0;
        out_row_r <= out_row_r + RW'(1);
      end else begin
        out_col_r <= out_col_r + CW'(1);
      end
    end
  end

  // Sums are latched first; the three means are formed in the following cycle.
  logic [7:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_mean
    bb3_div u_div (
      .sum   (sum_r[k]),
      .count (count_r),
      .quo   (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) calc_r <= 1'b0;
    else calc_r <= cmd.div_start;
    if (stat.take) pix_r <= pix;
    if (cmd.div_start) begin
      for (int k = 0; k < 3; k++) sum_r[k] <= s[k];
      count_r <= bb3_pkg::nb_count(nr, nc);
      done_r  <= done_c;
    end
    if (calc_r) begin
      for (int k = 0; k < 3; k++) res_r[k] <= quo[k];
    end
  end

  assign stat = '{take: drain != pixel_phase, emit: primed_r,
                  div_busy: cmd.div_start || calc_r};
  assign out_word = '{red_out: res_r[0], green_out: res_r[1], blue_out: res_r[2],
                      frame_done: done_r};

endmodule

// File: rtl/bb3_ctrl.sv
module bb3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bb3_pkg::dp_stat_t stat,
  input  logic              done,
  output bb3_pkg::dp_cmd_t  cmd
);

  bb3_pkg::state_t state_r, state_nxt;
  logic            first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bb3_pkg::ST_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      bb3_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        // Ignored words are taken and dropped.
        if (in_valid && stat.take) state_nxt = bb3_pkg::ST_SHIFT;
      end
      bb3_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = bb3_pkg::ST_DIV;
        first_nxt = 1'b1;
      end
      bb3_pkg::ST_DIV: begin
        if (!stat.emit) begin
          state_nxt = bb3_pkg::ST_IDLE;
        end else if (first_r) begin
          cmd.div_start = 1'b1;
          first_nxt     = 1'b0;
        end else if (!stat.div_busy) begin
          state_nxt = bb3_pkg::ST_OUT;
        end
      end
      bb3_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.restart = done;
          state_nxt   = bb3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bb3_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/box_blur_3x3_rgb_core.sv
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall   | bb3_pkg::in_word_t
// out_    | output    | out_valid / out_stall | bb3_pkg::out_word_t
// cfg_    | input     | cfg_we                | cfg_index, cfg_data
// A pixel word is taken in the idle state, then shifts the window and line stores; in the
// divide state the sums are latched, the means formed by reciprocal multiplication and
// handed over, and the result is then offered until it is not stalled. A word that gives
// no pixel passes only the take, shift and divide states; an ignored word is only taken.
// Reset is synchronous and clears counters, window and sizes (1024 x 1024 at the default
// maximum); the line stores are not cleared. While a result is stalled, no input is taken.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bb3_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bb3_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0] cfg_data
);

  bb3_pkg::dp_cmd_t  cmd;
  bb3_pkg::dp_stat_t stat;

  bb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .done      (out_word.frame_done),
    .cmd       (cmd)
  );

  bb3_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule
